/* rtl/core/mis_pkg.sv */
`timescale 1ns / 1ps

package mis_pkg;

  // Widths of the item fields.
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned RAND_W   = 16;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned ENERGY_W = 15;
  localparam int unsigned MAG_W    = 14;
  localparam int unsigned HSUM_W   = 4;

  // Wide enough for row * side + col at the largest lattice.
  localparam int unsigned ADDR_CALC_W = 2 * COORD_W + 1;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 32;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THR_TWO  = 2'd0,
    REG_THR_FOUR = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_UPDATE = 1'b1
  } req_type_e;

  // Flip decision. The product of the centre spin and the neighbour sum is
  // formed by the caller; a load flips only when the stored value differs.
  function automatic logic flip_decide(
    input logic                     req_type,
    input logic                     load_value,
    input logic                     centre_spin,
    input logic signed [HSUM_W-1:0] prod,
    input logic [RAND_W-1:0]        random_value,
    input logic [THR_W-1:0]         thr_two,
    input logic [THR_W-1:0]         thr_four
  );
    logic change;
    if (req_type == REQ_LOAD) begin
      change = (load_value != centre_spin);
    end else if (prod <= 0) begin
      change = 1'b1;
    end else if (prod == 2) begin
      change = (random_value <= thr_two);
    end else begin
      change = (random_value <= thr_four);
    end
    return change;
  endfunction

endpackage

/* rtl/core/mis_ram.sv */
`timescale 1ns / 1ps

module mis_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/metropolis_ising_spin_update.sv */
`timescale 1ns / 1ps

// Channel   Direction  Signals                        Contents
// s_axis    in         tvalid tready tdata tuser      one load or update request
// m_axis    out        tvalid tready tdata            spin, flip flag, totals, error
// cfg       in         cfg_valid cfg_ready index data threshold register writes
//
// An in-range request passes from transfer to result through five reads of the
// single-port lattice RAM (centre and four neighbours, one per cycle), a state
// that takes the last read word, and a state for the decision and write-back.
// A request with a site outside the lattice goes from idle straight to the result state, with no reads.
// After reset the lattice is swept to +1, one site a cycle, over all
// LATTICE_SIDE * LATTICE_SIDE sites; no request is taken meanwhile.
// A held result stalls the decision cycle of the next request until it is taken.

module metropolis_ising_spin_update import mis_pkg::*; #(
  parameter int unsigned LATTICE_SIDE = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [5:0] row, [11:6] col, [12] spin_value, [28:13] random_value, [31:29] zero
  input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] req_type
  input  logic                    s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [0] new_spin, [1] flipped, [16:2] total_energy, [30:17] total_magnetization,
  // [31] coord_error
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
  localparam int unsigned AW = $clog2(SITE_COUNT);

  localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * int'(SITE_COUNT));
  localparam logic signed [MAG_W-1:0]    MAG_RESET    = MAG_W'(SITE_COUNT);
  localparam logic signed [MAG_W-1:0]    MAG_STEP     = MAG_W'(2);
  localparam logic signed [HSUM_W-1:0]   ACC_STEP     = HSUM_W'(1);
  localparam logic [COORD_W-1:0]         LAST_COORD   = COORD_W'(LATTICE_SIDE - 1);
  localparam logic [COORD_W:0]           SIDE_EXT     = (COORD_W + 1)'(LATTICE_SIDE);
  localparam logic [AW-1:0]              LAST_SITE    = AW'(SITE_COUNT - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD_C  = 4'd2;
  localparam logic [3:0] S_RD_U  = 4'd3;
  localparam logic [3:0] S_RD_D  = 4'd4;
  localparam logic [3:0] S_RD_L  = 4'd5;
  localparam logic [3:0] S_RD_R  = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  function automatic logic [AW-1:0] site_addr(input logic [COORD_W-1:0] r,
                                              input logic [COORD_W-1:0] c);
    logic [ADDR_CALC_W-1:0] full;
    full = ADDR_CALC_W'(r) * ADDR_CALC_W'(LATTICE_SIDE) + ADDR_CALC_W'(c);
    return full[AW-1:0];
  endfunction

  logic [3:0]                  state_q, state_d;
  logic [AW-1:0]               clr_cnt_q, clr_cnt_d;
  logic                        req_q, req_d;
  logic [COORD_W-1:0]          row_q, row_d;
  logic [COORD_W-1:0]          col_q, col_d;
  logic                        load_q, load_d;
  logic [RAND_W-1:0]           rnd_q, rnd_d;
  logic                        err_q, err_d;
  logic                        spin_c_q, spin_c_d;
  logic signed [HSUM_W-1:0]    acc_q, acc_d;
  logic [THR_W-1:0]            thr_two_q, thr_two_d;
  logic [THR_W-1:0]            thr_four_q, thr_four_d;
  logic signed [ENERGY_W-1:0]  energy_q, energy_d;
  logic signed [MAG_W-1:0]     mag_q, mag_d;
  logic                        out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]      out_data_q, out_data_d;

  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic                        mem_wdata;
  logic                        mem_rdata;

  logic [COORD_W-1:0]          up_row, down_row, left_col, right_col;
  logic [COORD_W-1:0]          in_row, in_col;
  logic                        in_err;
  logic signed [HSUM_W-1:0]    prod;
  logic                        change;
  logic                        new_spin;
  logic                        out_free;

  mis_ram #(
    .WIDTH (1),
    .DEPTH (SITE_COUNT)
  ) u_lattice (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign in_row = s_axis_tdata[COORD_W-1:0];
  assign in_col = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_err = ({1'b0, in_row} >= SIDE_EXT) || ({1'b0, in_col} >= SIDE_EXT);

  assign up_row    = (row_q == '0) ? LAST_COORD : row_q - 1'b1;
  assign down_row  = (row_q == LAST_COORD) ? '0 : row_q + 1'b1;
  assign left_col  = (col_q == '0) ? LAST_COORD : col_q - 1'b1;
  assign right_col = (col_q == LAST_COORD) ? '0 : col_q + 1'b1;

  // Spin times neighbour sum; the energy change of a flip is twice this.
  assign prod   = spin_c_q ? acc_q : -acc_q;
  assign change = flip_decide(req_q, load_q, spin_c_q, prod, rnd_q, thr_two_q, thr_four_q);
  assign new_spin = change ? ~spin_c_q : spin_c_q;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    thr_two_d  = thr_two_q;
    thr_four_d = thr_four_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THR_TWO:  thr_two_d  = cfg_data_i[THR_W-1:0];
        REG_THR_FOUR: thr_four_d = cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    req_d       = req_q;
    row_d       = row_q;
    col_d       = col_q;
    load_d      = load_q;
    rnd_d       = rnd_q;
    err_d       = err_q;
    spin_c_d    = spin_c_q;
    acc_d       = acc_q;
    energy_d    = energy_q;
    mag_d       = mag_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_addr    = site_addr(row_q, col_q);
    mem_wdata   = 1'b1;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_SITE) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d   = s_axis_tuser;
          row_d   = in_row;
          col_d   = in_col;
          load_d  = s_axis_tdata[2*COORD_W];
          rnd_d   = s_axis_tdata[2*COORD_W+RAND_W:2*COORD_W+1];
          err_d   = in_err;
          state_d = in_err ? S_DONE : S_RD_C;
        end
      end
      S_RD_C: begin
        acc_d   = '0;
        state_d = S_RD_U;
      end
      S_RD_U: begin
        mem_addr = site_addr(up_row, col_q);
        spin_c_d = mem_rdata;
        state_d  = S_RD_D;
      end
      S_RD_D: begin
        mem_addr = site_addr(down_row, col_q);
        acc_d    = mem_rdata ? acc_q + ACC_STEP : acc_q - ACC_STEP;
        state_d  = S_RD_L;
      end
      S_RD_L: begin
        mem_addr = site_addr(row_q, left_col);
        acc_d    = mem_rdata ? acc_q + ACC_STEP : acc_q - ACC_STEP;
        state_d  = S_RD_R;
      end
      S_RD_R: begin
        mem_addr = site_addr(row_q, right_col);
        acc_d    = mem_rdata ? acc_q + ACC_STEP : acc_q - ACC_STEP;
        state_d  = S_SUM;
      end
      S_SUM: begin
        acc_d   = mem_rdata ? acc_q + ACC_STEP : acc_q - ACC_STEP;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          if (err_q) begin
            out_data_d = {1'b1, mag_q, energy_q, 1'b0, 1'b0};
          end else begin
            mem_we    = change;
            mem_wdata = new_spin;
            if (change) begin
              energy_d = energy_q + {{(ENERGY_W-HSUM_W-1){prod[HSUM_W-1]}}, prod, 1'b0};
              mag_d    = spin_c_q ? mag_q - MAG_STEP : mag_q + MAG_STEP;
            end
            out_data_d = {1'b0, mag_d, energy_d, change, new_spin};
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      thr_two_q   <= '0;
      thr_four_q  <= '0;
      energy_q    <= ENERGY_RESET;
      mag_q       <= MAG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      thr_two_q   <= thr_two_d;
      thr_four_q  <= thr_four_d;
      energy_q    <= energy_d;
      mag_q       <= mag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    row_q      <= row_d;
    col_q      <= col_d;
    load_q     <= load_d;
    rnd_q      <= rnd_d;
    err_q      <= err_d;
    spin_c_q   <= spin_c_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  // The lattice is written only by the reset sweep and the write-back cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_DONE))
    else $error("lattice written outside sweep or write-back");

  // Every flip moves the magnetization by two, so its parity never changes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q[0] == MAG_RESET[0])
    else $error("magnetization parity broken");

  // Bond energy is a sum over an even number of bonds and stays even.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    energy_q[0] == 1'b0)
    else $error("energy total is odd");

  // A site outside the lattice never reports a flip.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[OUT_TDATA_W-1] && m_axis_tdata[1]))
    else $error("flip reported for an out-of-range site");

endmodule

/* sim/tb_metropolis_ising_spin_update.sv */
`timescale 1ns / 1ps

module tb_metropolis_ising_spin_update;
  import mis_pkg::*;

  localparam int unsigned SIDE            = 32;
  localparam int unsigned SITES           = SIDE * SIDE;
  localparam int unsigned COORD_MAX       = (1 << COORD_W) - 1;
  localparam int unsigned ITEMS_PER_PHASE = 350;
  localparam int unsigned PHASES          = 5;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_REPORTS     = 10;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_SOURCE,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [2:0]        pad;
    logic [RAND_W-1:0] random_value;
    logic              spin_value;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } spin_request_t;

  typedef struct packed {
    logic                       coord_error;
    logic signed [MAG_W-1:0]    total_magnetization;
    logic signed [ENERGY_W-1:0] total_energy;
    logic                       flipped;
    logic                       new_spin;
  } spin_result_t;

  class spin_scoreboard;
    bit               lattice [SITES];
    int               energy;
    int               magnetization;
    logic [THR_W-1:0] thr_two;
    logic [THR_W-1:0] thr_four;
    spin_result_t     result_q [$];
    int               mismatches;

    function new();
      foreach (lattice[i]) lattice[i] = 1'b1;
      energy        = -2 * int'(SITES);
      magnetization = int'(SITES);
      thr_two       = '0;
      thr_four      = '0;
      mismatches    = 0;
    endfunction

    function int spin_of(int unsigned r, int unsigned c);
      return lattice[r * SIDE + c] ? 1 : -1;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THR_TWO:  thr_two = data;
        REG_THR_FOUR: thr_four = data;
        default: ;
      endcase
    endfunction

    function void note_request(logic req, spin_request_t rq);
      spin_result_t res;
      int unsigned  r, c, idx;
      int           s, h, prod;
      bit           change;
      res = '0;
      r = 32'(rq.row);
      c = 32'(rq.col);
      if (r >= SIDE || c >= SIDE) begin
        res.coord_error = 1'b1;
      end else begin
        idx = r * SIDE + c;
        s = spin_of(r, c);
        h = spin_of((r + SIDE - 1) % SIDE, c) + spin_of((r + 1) % SIDE, c)
          + spin_of(r, (c + SIDE - 1) % SIDE) + spin_of(r, (c + 1) % SIDE);
        prod = h * s;
        if (req == REQ_LOAD) begin
          change = (rq.spin_value != lattice[idx]);
        end else if (prod <= 0) begin
          change = 1'b1;
        end else if (prod == 2) begin
          change = (rq.random_value <= thr_two);
        end else begin
          change = (rq.random_value <= thr_four);
        end
        if (change) begin
          energy += 2 * s * h;
          magnetization -= 2 * s;
          lattice[idx] = ~lattice[idx];
          res.flipped = 1'b1;
        end
        res.new_spin = lattice[idx];
      end
      res.total_energy        = energy[ENERGY_W-1:0];
      res.total_magnetization = magnetization[MAG_W-1:0];
      result_q.push_back(res);
    endfunction

    function void check_result(spin_result_t act);
      spin_result_t want;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result transfer with nothing outstanding: %h", $realtime, act);
        return;
      end
      want = result_q.pop_front();
      if (act.new_spin !== want.new_spin || act.flipped !== want.flipped ||
          act.total_energy !== want.total_energy ||
          act.total_magnetization !== want.total_magnetization ||
          act.coord_error !== want.coord_error) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: mismatch (expected/actual) new_spin %0b/%0b flipped %0b/%0b",
                    " energy %0d/%0d magnetization %0d/%0d coord_error %0b/%0b"},
                   $realtime, want.new_spin, act.new_spin, want.flipped, act.flipped,
                   $signed(want.total_energy), $signed(act.total_energy),
                   $signed(want.total_magnetization), $signed(act.total_magnetization),
                   want.coord_error, act.coord_error);
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_requests = 0;

  spin_scoreboard sb = new();

  metropolis_ising_spin_update #(
    .LATTICE_SIDE(SIDE)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Results are checked before the input of the same edge is noted, so an
  // empty store is never mistaken for the request just taken.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
  end

  initial begin : result_sink
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_request(input logic req, input logic [COORD_W-1:0] row,
                              input logic [COORD_W-1:0] col, input logic spin,
                              input logic [RAND_W-1:0] rnd);
    spin_request_t rq;
    rq = '0;
    rq.row = row;
    rq.col = col;
    rq.spin_value = spin;
    rq.random_value = rnd;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rq;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_request();
    logic               req;
    logic               spin;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [RAND_W-1:0]  rnd;
    logic [THR_W-1:0]   thr;
    int                 pick;
    pick = $urandom_range(99);
    req  = (pick >= 30) ? REQ_UPDATE : REQ_LOAD;
    if ($urandom_range(1)) begin
      // A small window straddling the wrap keeps neighbours interacting.
      row = COORD_W'(($urandom_range(3) + SIDE - 2) % SIDE);
      col = COORD_W'(($urandom_range(3) + SIDE - 2) % SIDE);
    end else begin
      row = COORD_W'($urandom_range(SIDE - 1));
      col = COORD_W'($urandom_range(SIDE - 1));
    end
    if (pick % 10 == 0) begin
      case ($urandom_range(2))
        0: row = COORD_W'($urandom_range(COORD_MAX, SIDE));
        1: col = COORD_W'($urandom_range(COORD_MAX, SIDE));
        default: begin
          row = COORD_W'($urandom_range(COORD_MAX, SIDE));
          col = COORD_W'($urandom_range(COORD_MAX, SIDE));
        end
      endcase
    end
    spin = 1'($urandom_range(1));
    thr  = $urandom_range(1) ? sb.thr_two : sb.thr_four;
    if ($urandom_range(3) == 0) rnd = RAND_W'(32'(thr) + $urandom_range(2) - 1);
    else rnd = RAND_W'($urandom);
    send_request(req, row, col, spin, rnd);
  endtask

  initial begin : stimulus
    idle_mode_e mode;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Thresholds are still zero here: a p of 4 flips only when the random
    // value is zero, and a p of 2 never flips otherwise.
    send_request(REQ_UPDATE, 6'd0, 6'd0, 1'b0, 16'h0000);
    send_request(REQ_UPDATE, 6'd0, 6'd1, 1'b1, 16'h0001);
    send_request(REQ_LOAD, 6'd0, 6'd0, 1'b1, 16'hFFFF);
    send_request(REQ_LOAD, 6'd0, 6'd0, 1'b1, 16'h0000);
    send_request(REQ_LOAD, 6'd31, 6'd31, 1'b0, 16'h1234);
    send_request(REQ_UPDATE, 6'd0, 6'd31, 1'b0, 16'hFFFF);
    send_request(REQ_UPDATE, 6'd32, 6'd0, 1'b1, 16'hFFFF);
    send_request(REQ_LOAD, 6'd0, 6'd63, 1'b0, 16'h0000);
    send_request(REQ_UPDATE, 6'd63, 6'd63, 1'b1, 16'h0000);
    // Surround one site with down spins for a product of -4, then of +4.
    send_request(REQ_LOAD, 6'd4, 6'd5, 1'b0, 16'h0000);
    send_request(REQ_LOAD, 6'd6, 6'd5, 1'b0, 16'h0000);
    send_request(REQ_LOAD, 6'd5, 6'd4, 1'b0, 16'h0000);
    send_request(REQ_LOAD, 6'd5, 6'd6, 1'b0, 16'h0000);
    send_request(REQ_UPDATE, 6'd5, 6'd5, 1'b1, 16'hFFFF);
    send_request(REQ_UPDATE, 6'd5, 6'd5, 1'b1, 16'hFFFF);
    // Two down neighbours give a zero product, which always flips.
    send_request(REQ_LOAD, 6'd10, 6'd9, 1'b0, 16'h0000);
    send_request(REQ_LOAD, 6'd10, 6'd11, 1'b0, 16'h0000);
    send_request(REQ_UPDATE, 6'd10, 6'd10, 1'b0, 16'hFFFF);
    wait_idle();
    write_reg(REG_THR_TWO, 16'hFFFF);
    write_reg(REG_THR_FOUR, 16'hFFFF);
    send_request(REQ_UPDATE, 6'd0, 6'd31, 1'b1, 16'hFFFF);
    send_request(REQ_UPDATE, 6'd5, 6'd5, 1'b1, 16'hFFFF);
    send_request(REQ_UPDATE, 6'd20, 6'd20, 1'b1, 16'hFFFF);
    wait_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_THR_TWO, 16'h0000);
          write_reg(REG_THR_FOUR, 16'h0000);
        end
        1: begin
          write_reg(REG_THR_TWO, 16'hFFFF);
          write_reg(REG_THR_FOUR, 16'hFFFF);
        end
        3: begin
          write_reg(REG_THR_TWO, 16'hFFFF);
          write_reg(REG_THR_FOUR, 16'h0000);
          write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        end
        default: begin
          write_reg(REG_THR_TWO, CFG_DATA_W'($urandom));
          write_reg(REG_THR_FOUR, CFG_DATA_W'($urandom));
          write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        end
      endcase
      mode = idle_mode_e'(phase % 4);
      case (mode)
        IDLE_SOURCE: begin src_idle_pct = 53; sink_stall_pct = 0;  end
        IDLE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 53; end
        IDLE_BOTH:   begin src_idle_pct = 6;  sink_stall_pct = 6;  end
        default:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // The long hold-off lets the block back up into its input.
        if (n == ITEMS_PER_PHASE / 3 && (mode == IDLE_NONE || mode == IDLE_BOTH))
          hold_requests++;
        if (n == 2 * ITEMS_PER_PHASE / 3 && mode != IDLE_SINK) wait_idle();
        send_random_request();
      end
      wait_idle();
    end

    src_idle_pct = 0;
    sink_stall_pct = 0;
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("metropolis_ising_spin_update verification clean");
    end else begin
      $display("metropolis_ising_spin_update verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("metropolis_ising_spin_update verification failed");
    $finish;
  end

endmodule
